[rtl/irc_tok_pkg.sv]
// ----------------------------------------------------------------------------
// irc_tok_pkg
// Shared types and constants of the IRC line tokenizer: result record,
// result bundle, character codes, field classes and parser phases.
// ----------------------------------------------------------------------------
package irc_tok_pkg;

  // Default saturation limit of the parameter index
  localparam int MAX_PARAMS_DEF = 15;

  // Most results that one input byte can cause
  localparam int RES_MAX = 3;

  // Character codes
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_CASE  = 8'h20;

  // Field classes
  localparam logic [2:0] CLS_NICK  = 3'd0;
  localparam logic [2:0] CLS_USER  = 3'd1;
  localparam logic [2:0] CLS_HOST  = 3'd2;
  localparam logic [2:0] CLS_CMD   = 3'd3;
  localparam logic [2:0] CLS_PARAM = 3'd4;

  // Parser phases
  localparam logic [2:0] PH_START = 3'd0;
  localparam logic [2:0] PH_NICK  = 3'd1;
  localparam logic [2:0] PH_USER  = 3'd2;
  localparam logic [2:0] PH_HOST  = 3'd3;
  localparam logic [2:0] PH_CMD   = 3'd4;
  localparam logic [2:0] PH_PARAM = 3'd5;
  localparam logic [2:0] PH_TRAIL = 3'd6;

  // One result record
  typedef struct packed {
    logic [7:0]         byte_out;
    logic               byte_valid;
    logic [2:0]         field_class;
    logic [3:0]         param_slot;
    logic               token_end;
    logic               code_numeric;
    logic signed [31:0] code_value;
    logic               line_done;
    logic               run_last;
  } res_t;

  typedef res_t [0:RES_MAX-1] res_arr_t;

  // Results of one input byte and how many of them are live
  typedef struct packed {
    res_arr_t   res;
    logic [1:0] cnt;
  } bundle_t;

  // Parser status, for checking
  typedef struct packed {
    logic [2:0] phase;
    logic       token_open;
    logic [1:0] hold_count;
  } tok_stat_t;

  function automatic res_t mk_res(input logic [7:0] b, input logic v,
                                  input logic [2:0] cls, input logic [3:0] slot,
                                  input logic te, input logic num,
                                  input logic signed [31:0] val);
    res_t r;
    r.byte_out     = b;
    r.byte_valid   = v;
    r.field_class  = cls;
    r.param_slot   = slot;
    r.token_end    = te;
    r.code_numeric = num;
    r.code_value   = val;
    r.line_done    = 1'b0;
    r.run_last     = 1'b0;
    return r;
  endfunction

endpackage

[rtl/irc_tok_core.sv]
// ----------------------------------------------------------------------------
// irc_tok_core
// Per-byte tokenizer: parser state registers and the single-pass logic that
// turns one byte into its bundle of up to three results.
// ----------------------------------------------------------------------------
module irc_tok_core #(
  parameter int MAX_PARAMS = irc_tok_pkg::MAX_PARAMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            char_byte,
  input  logic                  line_last,
  output irc_tok_pkg::bundle_t  bundle,
  output irc_tok_pkg::tok_stat_t stat
);
  import irc_tok_pkg::*;

  localparam logic [3:0] SLOT_CAP = (MAX_PARAMS < 15) ? 4'(MAX_PARAMS) : 4'd15;

  // Command number flags: sign seen, negative, digit seen
  localparam logic [2:0] FL_SIGN  = 3'b001;
  localparam logic [2:0] FL_NEG   = 3'b010;
  localparam logic [2:0] FL_DIGIT = 3'b100;
  localparam logic [2:0] FL_BAD   = 3'b010;

  localparam logic signed [35:0] LIM_HI = 36'sh07FFFFFFF;
  localparam logic signed [35:0] LIM_LO = 36'shF80000000;

  // Parser state
  logic [2:0]         ph_r, ph_nxt;
  logic               open_r, open_nxt;
  logic [7:0]         hb0_r, hb0_nxt;
  logic [7:0]         hb1_r, hb1_nxt;
  logic [1:0]         hc_r, hc_nxt;
  logic [3:0]         pc_r, pc_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic [2:0]         fl_r, fl_nxt;

  logic               is_ws;
  logic [7:0]         upc;
  logic               do_cmd, do_push, do_close;
  logic [2:0]         last_cls;
  logic [3:0]         last_slot;
  logic [1:0]         n;
  res_arr_t           res;

  // Number parse of the upper-cased byte
  logic signed [35:0] acc_ext, m10, dig_ext, sum;
  logic               ovf, is_dig;
  logic [2:0]         pd_fl;
  logic signed [31:0] pd_acc;

  function automatic res_t cmd_end(input logic [2:0] fl, input logic signed [31:0] acc);
    logic ok;
    ok = (fl != FL_BAD) && fl[2];
    return mk_res(8'd0, 1'b0, CLS_CMD, 4'd0, 1'b1, ok, ok ? acc : 32'shFFFFFFFF);
  endfunction

  assign is_ws = (char_byte inside {[8'd9:8'd13], CH_SPACE});
  assign upc   = ((char_byte >= CH_LA) && (char_byte <= CH_LZ)) ?
                 (char_byte - CH_CASE) : char_byte;

  // Signed accumulate: the value is built with its sign, so no negate at the end
  assign acc_ext = 36'(acc_r);
  assign m10     = (acc_ext <<< 3) + (acc_ext <<< 1);
  assign dig_ext = $signed({32'd0, upc[3:0]});
  assign sum     = fl_r[1] ? (m10 - dig_ext) : (m10 + dig_ext);
  assign ovf     = (sum > LIM_HI) || (sum < LIM_LO);
  assign is_dig  = (upc >= CH_ZERO) && (upc <= CH_NINE);

  always_comb begin
    pd_fl  = fl_r;
    pd_acc = acc_r;
    if (fl_r == FL_BAD) begin
      pd_fl = fl_r;
    end else if (((upc == CH_PLUS) || (upc == CH_MINUS)) && (fl_r == 3'b000)) begin
      pd_fl = FL_SIGN | ((upc == CH_MINUS) ? FL_NEG : 3'b000);
    end else if (is_dig) begin
      if (ovf) begin
        pd_fl = FL_BAD;
      end else begin
        pd_acc = sum[31:0];
        pd_fl  = fl_r | FL_DIGIT;
      end
    end else begin
      pd_fl = FL_BAD;
    end
  end

  // Byte handling and result bundle
  always_comb begin
    ph_nxt    = ph_r;
    open_nxt  = open_r;
    hb0_nxt   = hb0_r;
    hb1_nxt   = hb1_r;
    hc_nxt    = hc_r;
    pc_nxt    = pc_r;
    acc_nxt   = acc_r;
    fl_nxt    = fl_r;
    do_cmd    = 1'b0;
    do_push   = 1'b0;
    do_close  = 1'b0;
    last_cls  = CLS_CMD;
    last_slot = 4'd0;
    n         = 2'd0;
    for (int i = 0; i < RES_MAX; i++) begin
      res[i] = '0;
    end

    // Phase dispatch
    case (ph_r)
      PH_START: begin
        if (char_byte == CH_COLON) begin
          ph_nxt = PH_NICK;
        end else begin
          ph_nxt = PH_CMD;
          do_cmd = 1'b1;
        end
      end
      PH_NICK: begin
        if (char_byte == CH_BANG) begin
          res[n] = mk_res(8'd0, 1'b0, CLS_NICK, 4'd0, 1'b1, 1'b0, 32'sd0);
          n = n + 2'd1;
          ph_nxt = PH_USER;
        end else if (is_ws) begin
          res[n] = mk_res(8'd0, 1'b0, CLS_NICK, 4'd0, 1'b1, 1'b0, 32'sd0);
          n = n + 2'd1;
          ph_nxt = PH_CMD;
        end else begin
          res[n] = mk_res(char_byte, 1'b1, CLS_NICK, 4'd0, 1'b0, 1'b0, 32'sd0);
          n = n + 2'd1;
        end
      end
      PH_USER: begin
        if (char_byte == CH_AT) begin
          res[n] = mk_res(8'd0, 1'b0, CLS_USER, 4'd0, 1'b1, 1'b0, 32'sd0);
          ph_nxt = PH_HOST;
        end else begin
          res[n] = mk_res(char_byte, 1'b1, CLS_USER, 4'd0, 1'b0, 1'b0, 32'sd0);
        end
        n = n + 2'd1;
      end
      PH_HOST: begin
        if (char_byte == CH_SPACE) begin
          res[n] = mk_res(8'd0, 1'b0, CLS_HOST, 4'd0, 1'b1, 1'b0, 32'sd0);
          ph_nxt = PH_CMD;
        end else begin
          res[n] = mk_res(char_byte, 1'b1, CLS_HOST, 4'd0, 1'b0, 1'b0, 32'sd0);
        end
        n = n + 2'd1;
      end
      PH_CMD: begin
        do_cmd = 1'b1;
      end
      PH_PARAM: begin
        if (open_r) begin
          if (is_ws) begin
            do_close = 1'b1;
          end else begin
            do_push = 1'b1;
          end
        end else if (char_byte == CH_COLON) begin
          ph_nxt = PH_TRAIL;
        end else if (!is_ws) begin
          do_push = 1'b1;
        end
      end
      default: begin
        ph_nxt  = PH_TRAIL;
        do_push = 1'b1;
      end
    endcase

    // Command byte: upper-case and parse, or close the command on whitespace
    if (do_cmd) begin
      if (is_ws) begin
        res[n] = cmd_end(fl_r, acc_r);
        n = n + 2'd1;
        ph_nxt = PH_PARAM;
      end else begin
        res[n] = mk_res(upc, 1'b1, CLS_CMD, 4'd0, 1'b0, 1'b0, 32'sd0);
        n = n + 2'd1;
        fl_nxt  = pd_fl;
        acc_nxt = pd_acc;
      end
    end

    // Parameter byte: the two newest bytes stay held back
    if (do_push) begin
      if (hc_r == 2'd2) begin
        res[n] = mk_res(hb0_r, 1'b1, CLS_PARAM, pc_r, 1'b0, 1'b0, 32'sd0);
        n = n + 2'd1;
        hb0_nxt = hb1_r;
        hb1_nxt = char_byte;
      end else if (hc_r == 2'd0) begin
        hb0_nxt = char_byte;
        hc_nxt  = 2'd1;
      end else begin
        hb1_nxt = char_byte;
        hc_nxt  = 2'd2;
      end
      open_nxt = 1'b1;
    end

    // Whitespace closes a parameter and releases its held bytes
    if (do_close) begin
      if (hc_r != 2'd0) begin
        res[n] = mk_res(hb0_r, 1'b1, CLS_PARAM, pc_r, 1'b0, 1'b0, 32'sd0);
        n = n + 2'd1;
      end
      if (hc_r == 2'd2) begin
        res[n] = mk_res(hb1_r, 1'b1, CLS_PARAM, pc_r, 1'b0, 1'b0, 32'sd0);
        n = n + 2'd1;
      end
      res[n] = mk_res(8'd0, 1'b0, CLS_PARAM, pc_r, 1'b1, 1'b0, 32'sd0);
      n = n + 2'd1;
      hc_nxt   = 2'd0;
      open_nxt = 1'b0;
      if (pc_r < SLOT_CAP) begin
        pc_nxt = pc_r + 4'd1;
      end
    end

    // Line end: close what is open, drop held bytes, mark the last result
    if (line_last) begin
      if ((ph_nxt == PH_PARAM) || (ph_nxt == PH_TRAIL)) begin
        if (open_nxt) begin
          res[n] = mk_res(8'd0, 1'b0, CLS_PARAM, pc_nxt, 1'b1, 1'b0, 32'sd0);
          n = n + 2'd1;
          if (pc_nxt < SLOT_CAP) begin
            pc_nxt = pc_nxt + 4'd1;
          end
        end
        last_cls  = CLS_PARAM;
        last_slot = pc_nxt;
      end else if ((ph_nxt == PH_NICK) || (ph_nxt == PH_USER) || (ph_nxt == PH_HOST)) begin
        res[n] = mk_res(8'd0, 1'b0, ph_nxt - PH_NICK, 4'd0, 1'b1, 1'b0, 32'sd0);
        n = n + 2'd1;
      end else begin
        res[n] = cmd_end(fl_nxt, acc_nxt);
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        res[n] = mk_res(8'd0, 1'b0, last_cls, last_slot, 1'b0, 1'b0, 32'sd0);
        n = n + 2'd1;
      end
      res[n - 2'd1].line_done = 1'b1;
      ph_nxt   = PH_START;
      open_nxt = 1'b0;
      hc_nxt   = 2'd0;
      pc_nxt   = 4'd0;
      acc_nxt  = 32'sd0;
      fl_nxt   = 3'b000;
    end

    if (n != 2'd0) begin
      res[n - 2'd1].run_last = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_START;
      open_r <= 1'b0;
      hc_r   <= 2'd0;
      pc_r   <= 4'd0;
      acc_r  <= 32'sd0;
      fl_r   <= 3'b000;
    end else if (take) begin
      ph_r   <= ph_nxt;
      open_r <= open_nxt;
      hc_r   <= hc_nxt;
      pc_r   <= pc_nxt;
      acc_r  <= acc_nxt;
      fl_r   <= fl_nxt;
    end
  end

  // Held parameter bytes, read only below the hold count
  always_ff @(posedge clk) begin
    if (take) begin
      hb0_r <= hb0_nxt;
      hb1_r <= hb1_nxt;
    end
  end

  assign bundle.res = res;
  assign bundle.cnt = n;

  assign stat.phase      = ph_r;
  assign stat.token_open = open_r;
  assign stat.hold_count = hc_r;

endmodule

[rtl/irc_tok_outq.sv]
// ----------------------------------------------------------------------------
// irc_tok_outq
// Result register: holds the bundle of one byte and hands its results out
// one transaction at a time, shifting the next one to the front.
// ----------------------------------------------------------------------------
module irc_tok_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  irc_tok_pkg::bundle_t bundle,
  output logic                 ready,
  output logic                 out_valid,
  input  logic                 out_stall,
  output irc_tok_pkg::res_t    head
);
  import irc_tok_pkg::*;

  res_t       ent_r [0:RES_MAX-1];
  logic [1:0] rem_r;
  logic       pop;

  assign out_valid = (rem_r != 2'd0);
  assign pop       = out_valid && !out_stall;
  // New bundle fits when empty or when the final pending result leaves now
  assign ready     = (rem_r == 2'd0) || ((rem_r == 2'd1) && !out_stall);
  assign head      = ent_r[0];

  // Count of pending results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= 2'd0;
    end else if (load) begin
      rem_r <= bundle.cnt;
    end else if (pop) begin
      rem_r <= rem_r - 2'd1;
    end
  end

  // Result entries
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RES_MAX; i++) begin
        ent_r[i] <= bundle.res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        ent_r[i] <= ent_r[i + 1];
      end
    end
  end

endmodule

[rtl/irc_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// irc_line_tokenizer
// Byte-serial tokenizer for IRC server lines: prefix, command and parameters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one byte of a server line per
//   transaction, in_line_last set on the final byte of the line.
//   Result channel (out_valid / out_stall): zero to three results per byte,
//   each a labeled byte, a field end or a line-end marker; out_run_last
//   flags the last result of a byte, out_line_done the last of a line.
//   Timing: results of a byte are registered and appear in the cycle
//   after its transaction. Throughput: one byte per cycle while each byte
//   gives at most one result and the receiver does not stall; a byte with
//   more results holds the result register until all of them have left.
//   The two newest parameter bytes are held back until the next byte.
//   Reset: parser returns to line start, the result register empties.
//   Receiver stall: pending results hold; in_stall rises once the last
//   pending result of the current byte cannot leave in this cycle.
// ----------------------------------------------------------------------------
module irc_line_tokenizer #(
  parameter int MAX_PARAMS = irc_tok_pkg::MAX_PARAMS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_char_byte,
  input  logic               in_line_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte_out,
  output logic               out_byte_valid,
  output logic [2:0]         out_field_class,
  output logic [3:0]         out_param_slot,
  output logic               out_token_end,
  output logic               out_code_numeric,
  output logic signed [31:0] out_code_value,
  output logic               out_line_done,
  output logic               out_run_last
);
  import irc_tok_pkg::*;

  logic      q_ready;
  logic      take;
  bundle_t   bundle;
  tok_stat_t stat;
  res_t      head;

  assign in_stall = !q_ready;
  assign take     = in_valid && q_ready;

  // Parser and per-byte result logic
  irc_tok_core #(
    .MAX_PARAMS(MAX_PARAMS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .char_byte (in_char_byte),
    .line_last (in_line_last),
    .bundle    (bundle),
    .stat      (stat)
  );

  // Result register and drain
  irc_tok_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take),
    .bundle    (bundle),
    .ready     (q_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_byte_out     = head.byte_out;
  assign out_byte_valid   = head.byte_valid;
  assign out_field_class  = head.field_class;
  assign out_param_slot   = head.param_slot;
  assign out_token_end    = head.token_end;
  assign out_code_numeric = head.code_numeric;
  assign out_code_value   = head.code_value;
  assign out_line_done    = head.line_done;
  assign out_run_last     = head.run_last;

  // The line end is always the last result of its byte
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_done) |-> out_run_last)
    else $error("line_done without run_last");

  // A field end never carries a byte
  a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_end) |-> !out_byte_valid)
    else $error("token_end with byte_valid");

  // After the final byte of a line the parser is back at line start
  a_line_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_line_last) |=>
      ((stat.phase == PH_START) && !stat.token_open && (stat.hold_count == 2'd0)))
    else $error("parser state not cleared after line end");

  // Never more than two bytes held back
  a_hold_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.hold_count != 2'd3)
    else $error("hold count out of range");

  // Accepting the final byte of a line always yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_line_last) |=> out_valid)
    else $error("line end produced no result");

endmodule

[test/tb_irc_line_tokenizer.sv]
// ----------------------------------------------------------------------------
// tb_irc_line_tokenizer
// Self-checking bench for the IRC line tokenizer. Server lines are fed one
// byte per transaction and every result is compared field by field against
// a line parser kept inside the bench. The run mixes a few hand-built lines
// with random well-formed and broken lines, under random and no idling on
// both channels, with one long receiver hold.
// ----------------------------------------------------------------------------
module tb_irc_line_tokenizer;
  import irc_tok_pkg::*;

  // Parse flag encodings of the numeric command check
  localparam logic [2:0] FLG_NONE  = 3'b000;
  localparam logic [2:0] FLG_SIGN  = 3'b001;
  localparam logic [2:0] FLG_NEG   = 3'b010;
  localparam logic [2:0] FLG_DIGIT = 3'b100;
  localparam logic [2:0] FLG_BAD   = 3'b010;  // negative without sign

  localparam logic [3:0] SLOT_TOP = 4'((MAX_PARAMS_DEF < 15) ? MAX_PARAMS_DEF : 15);

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_HI  = 8'h80;
  localparam logic [7:0] CH_MAX = 8'hFF;

  localparam int LONG_HOLD = 40;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } line_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_char_byte = '0;
  logic               in_line_last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_byte_out;
  logic               out_byte_valid;
  logic [2:0]         out_field_class;
  logic [3:0]         out_param_slot;
  logic               out_token_end;
  logic               out_code_numeric;
  logic signed [31:0] out_code_value;
  logic               out_line_done;
  logic               out_run_last;

  // Pending input bytes and tokens still to be seen on the result side
  line_item_t line_bytes_q[$];
  logic [7:0] line_buf[$];
  res_t       token_step_q[$];
  res_t       pending_tokens_q[$];

  // Parser state mirrored by the bench
  logic [2:0]  p_phase = PH_START;
  logic        p_open = 1'b0;
  logic [7:0]  p_hold[2];
  logic [1:0]  p_hcnt = '0;
  logic [3:0]  p_slot = '0;
  logic [31:0] p_acc = '0;
  logic [2:0]  p_flags = FLG_NONE;

  // Pacing controls; the idle and hold-request flags are written at the falling edge
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold_left = 0;

  int n_errors = 0;
  int n_pushed = 0;
  int n_lines = 0;
  int n_results = 0;

  irc_line_tokenizer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_byte     (in_char_byte),
    .in_line_last     (in_line_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_byte_valid   (out_byte_valid),
    .out_field_class  (out_field_class),
    .out_param_slot   (out_param_slot),
    .out_token_end    (out_token_end),
    .out_code_numeric (out_code_numeric),
    .out_code_value   (out_code_value),
    .out_line_done    (out_line_done),
    .out_run_last     (out_run_last)
  );

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- parser

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic void add_res(logic [7:0] b, logic v, logic [2:0] cls,
                                  logic [3:0] slot, logic te, logic num,
                                  logic [31:0] val);
    res_t r;
    r.byte_out     = b;
    r.byte_valid   = v;
    r.field_class  = cls;
    r.param_slot   = slot;
    r.token_end    = te;
    r.code_numeric = num;
    r.code_value   = val;
    r.line_done    = 1'b0;
    r.run_last     = 1'b0;
    token_step_q.push_back(r);
  endfunction

  function automatic void clear_line();
    p_phase = PH_START;
    p_open  = 1'b0;
    p_hcnt  = '0;
    p_slot  = '0;
    p_acc   = '0;
    p_flags = FLG_NONE;
  endfunction

  // Numeric check of the command, one upper-cased byte at a time
  function automatic void scan_code(logic [7:0] c);
    logic [63:0] lim;
    logic [63:0] v;
    if (p_flags == FLG_BAD)
      return;
    if ((c == CH_PLUS || c == CH_MINUS) && p_flags == FLG_NONE) begin
      p_flags = FLG_SIGN | ((c == CH_MINUS) ? FLG_NEG : FLG_NONE);
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      lim = (p_flags & FLG_NEG) ? 64'd2147483648 : 64'd2147483647;
      v = {32'd0, p_acc} * 64'd10 + {56'd0, c - CH_ZERO};
      if (v > lim) begin
        p_flags = FLG_BAD;
      end else begin
        p_acc   = v[31:0];
        p_flags = p_flags | FLG_DIGIT;
      end
    end else begin
      p_flags = FLG_BAD;
    end
  endfunction

  function automatic void close_command();
    logic        ok;
    logic [31:0] val;
    ok  = p_flags != FLG_BAD && (p_flags & FLG_DIGIT) != FLG_NONE;
    val = 32'hFFFF_FFFF;
    if (ok)
      val = (p_flags & FLG_NEG) ? -p_acc : p_acc;
    add_res(CH_NUL, 1'b0, CLS_CMD, '0, 1'b1, ok, val);
  endfunction

  function automatic void command_char(logic [7:0] c);
    logic [7:0] u;
    if (is_space(c)) begin
      close_command();
      p_phase = PH_PARAM;
      return;
    end
    u = (c >= CH_LA && c <= CH_LZ) ? c - CH_CASE : c;
    add_res(u, 1'b1, CLS_CMD, '0, 1'b0, 1'b0, '0);
    scan_code(u);
  endfunction

  // Parameter bytes go through a two-deep delay so a line-end CR LF can be cut
  function automatic void param_char(logic [7:0] c);
    if (p_hcnt >= 2) begin
      add_res(p_hold[0], 1'b1, CLS_PARAM, p_slot, 1'b0, 1'b0, '0);
      p_hold[0] = p_hold[1];
      p_hold[1] = c;
    end else begin
      p_hold[p_hcnt] = c;
      p_hcnt++;
    end
    p_open = 1'b1;
  endfunction

  function automatic void close_param(bit release_held);
    if (release_held)
      for (int i = 0; i < p_hcnt; i++)
        add_res(p_hold[i], 1'b1, CLS_PARAM, p_slot, 1'b0, 1'b0, '0);
    add_res(CH_NUL, 1'b0, CLS_PARAM, p_slot, 1'b1, 1'b0, '0);
    p_hcnt = '0;
    p_open = 1'b0;
    if (p_slot < SLOT_TOP)
      p_slot++;
  endfunction

  // Tokens produced by one accepted byte, appended to the pending list
  function automatic void tokenize_byte(logic [7:0] c, logic last);
    logic [2:0] cls;
    logic [3:0] slot;
    res_t       r;
    cls  = CLS_CMD;
    slot = '0;
    token_step_q.delete();
    case (p_phase)
      PH_START: begin
        if (c == CH_COLON) begin
          p_phase = PH_NICK;
        end else begin
          p_phase = PH_CMD;
          command_char(c);
        end
      end
      PH_NICK: begin
        if (c == CH_BANG) begin
          add_res(CH_NUL, 1'b0, CLS_NICK, '0, 1'b1, 1'b0, '0);
          p_phase = PH_USER;
        end else if (is_space(c)) begin
          add_res(CH_NUL, 1'b0, CLS_NICK, '0, 1'b1, 1'b0, '0);
          p_phase = PH_CMD;
        end else begin
          add_res(c, 1'b1, CLS_NICK, '0, 1'b0, 1'b0, '0);
        end
      end
      PH_USER: begin
        if (c == CH_AT) begin
          add_res(CH_NUL, 1'b0, CLS_USER, '0, 1'b1, 1'b0, '0);
          p_phase = PH_HOST;
        end else begin
          add_res(c, 1'b1, CLS_USER, '0, 1'b0, 1'b0, '0);
        end
      end
      PH_HOST: begin
        if (c == CH_SPACE) begin
          add_res(CH_NUL, 1'b0, CLS_HOST, '0, 1'b1, 1'b0, '0);
          p_phase = PH_CMD;
        end else begin
          add_res(c, 1'b1, CLS_HOST, '0, 1'b0, 1'b0, '0);
        end
      end
      PH_CMD: command_char(c);
      PH_PARAM: begin
        if (p_open) begin
          if (is_space(c))
            close_param(1'b1);
          else
            param_char(c);
        end else if (c == CH_COLON) begin
          p_phase = PH_TRAIL;
        end else if (!is_space(c)) begin
          param_char(c);
        end
      end
      default: begin
        p_phase = PH_TRAIL;
        param_char(c);
      end
    endcase

    // Line end: close whatever is open, held bytes are dropped
    if (last) begin
      if (p_phase == PH_PARAM || p_phase == PH_TRAIL) begin
        if (p_open)
          close_param(1'b0);
        cls  = CLS_PARAM;
        slot = p_slot;
      end else if (p_phase >= PH_NICK && p_phase <= PH_HOST) begin
        add_res(CH_NUL, 1'b0, CLS_NICK + (p_phase - PH_NICK), '0, 1'b1, 1'b0, '0);
      end else begin
        close_command();
      end
      if (token_step_q.size() == 0)
        add_res(CH_NUL, 1'b0, cls, slot, 1'b0, 1'b0, '0);
      r = token_step_q.pop_back();
      r.line_done = 1'b1;
      token_step_q.push_back(r);
      clear_line();
    end

    if (token_step_q.size() > 0) begin
      r = token_step_q.pop_back();
      r.run_last = 1'b1;
      token_step_q.push_back(r);
    end
    foreach (token_step_q[i])
      pending_tokens_q.push_back(token_step_q[i]);
  endfunction

  // ---------------------------------------------------------------- driver

  // Input transactions from the pending byte list, random gap per byte
  always @(posedge clk) begin : byte_driver
    line_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        tokenize_byte(in_char_byte, in_line_last);
      if (in_valid && in_stall) begin
        // stalled: payload holds
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (line_bytes_q.size() > 0) begin
        nxt = line_bytes_q.pop_front();
        in_char_byte <= nxt.ch;
        in_line_last <= nxt.last;
        in_valid     <= 1'b1;
        tx_gap = tx_idle ? $urandom_range(0, 8) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  function automatic void check_field(string name, logic [31:0] exp_v,
                                      logic [31:0] got);
    if (got !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got);
      n_errors++;
    end
  endfunction

  // Long receiver hold, counted in cycles on request
  always @(posedge clk) begin : long_hold
    if (!rst_n) begin
      rx_hold_left <= 0;
    end else if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      rx_hold_left <= LONG_HOLD;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end
  end

  // Result transactions checked in order; stall drawn per result
  always @(posedge clk) begin : token_monitor
    res_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_tokens_q.size() == 0) begin
          $error("result with none expected: byte_out %0h class %0d",
                 out_byte_out, out_field_class);
          n_errors++;
        end else begin
          e = pending_tokens_q.pop_front();
          check_field("byte_out", 32'(e.byte_out), 32'(out_byte_out));
          check_field("byte_valid", 32'(e.byte_valid), 32'(out_byte_valid));
          check_field("field_class", 32'(e.field_class), 32'(out_field_class));
          check_field("param_slot", 32'(e.param_slot), 32'(out_param_slot));
          check_field("token_end", 32'(e.token_end), 32'(out_token_end));
          check_field("code_numeric", 32'(e.code_numeric), 32'(out_code_numeric));
          check_field("code_value", e.code_value, out_code_value);
          check_field("line_done", 32'(e.line_done), 32'(out_line_done));
          check_field("run_last", 32'(e.run_last), 32'(out_run_last));
          n_results++;
        end
        rx_gap = rx_idle ? $urandom_range(0, 8) : 0;
      end
      if (rx_hold_left > 0) begin
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic void add_byte(logic [7:0] c);
    line_buf.push_back(c);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++)
      line_buf.push_back(s[i]);
  endfunction

  // Move the built line to the driver list, last byte flagged
  function automatic void flush_line();
    line_item_t it;
    if (line_buf.size() == 0)
      line_buf.push_back(8'($urandom_range(0, 255)));
    foreach (line_buf[i]) begin
      it.ch   = line_buf[i];
      it.last = (i == line_buf.size() - 1);
      line_bytes_q.push_back(it);
    end
    n_pushed += line_buf.size();
    n_lines++;
    line_buf.delete();
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'($urandom_range(0, 1) ? $urandom_range(CH_LA, CH_LZ)
                                   : $urandom_range(CH_LA - CH_CASE, CH_LZ - CH_CASE));
  endfunction

  function automatic logic [7:0] rand_space();
    return 8'(($urandom_range(0, 3) == 0) ? $urandom_range(CH_TAB, CH_CR) : CH_SPACE);
  endfunction

  // Non-whitespace byte: mostly printable, sometimes control or high half
  function automatic logic [7:0] rand_word_byte();
    int v;
    case ($urandom_range(0, 15))
      0: return 8'($urandom_range(128, 255));
      1: begin
        v = $urandom_range(0, 26);
        return 8'((v < 9) ? v : v + 5);
      end
      default: return 8'($urandom_range(33, 126));
    endcase
  endfunction

  // One random server line; some lines stop early or are plain noise
  task automatic gen_line(input bit many);
    longint limit_vals[6] = '{64'sd0, 64'sd2147483647, 64'sd2147483648,
                              -64'sd2147483648, -64'sd2147483649,
                              64'sd9999999999};
    longint val;
    if (!many && $urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(0, 255)));
      flush_line();
      return;
    end
    // prefix
    if (!many && $urandom_range(0, 1)) begin
      add_byte(CH_COLON);
      repeat ($urandom_range(0, 4)) add_byte(rand_letter());
      if ($urandom_range(0, 9) == 0) begin
        flush_line();
        return;
      end
      if ($urandom_range(0, 3) != 0) begin
        add_byte(CH_BANG);
        repeat ($urandom_range(0, 4)) add_byte(rand_letter());
        if ($urandom_range(0, 9) == 0) begin
          flush_line();
          return;
        end
        add_byte(CH_AT);
        repeat ($urandom_range(0, 5)) add_byte(rand_letter());
        if ($urandom_range(0, 9) == 0) begin
          flush_line();
          return;
        end
        add_byte(CH_SPACE);
      end else begin
        add_byte(rand_space());
      end
    end
    // command: numeric, alphabetic or arbitrary
    case ($urandom_range(0, 2))
      0: begin
        case ($urandom_range(0, 3))
          0: val = $urandom_range(0, 999);
          1: val = -longint'($urandom_range(0, 999));
          2: val = limit_vals[$urandom_range(0, 5)];
          default: val = longint'($urandom());
        endcase
        if (val >= 0 && $urandom_range(0, 3) == 0)
          add_byte(CH_PLUS);
        add_text($sformatf("%0d", val));
      end
      1: repeat ($urandom_range(1, 7)) add_byte(rand_letter());
      default: repeat ($urandom_range(0, 5)) add_byte(rand_word_byte());
    endcase
    if (!many && $urandom_range(0, 9) == 0) begin
      flush_line();
      return;
    end
    // middle parameters; a long run of them saturates the slot index
    repeat (many ? 17 : $urandom_range(0, 4)) begin
      repeat (many ? 1 : $urandom_range(1, 2)) add_byte(many ? CH_SPACE : rand_space());
      repeat (many ? 1 : $urandom_range(1, 4)) add_byte(rand_word_byte());
    end
    // trailing parameter, often ended by CR LF
    if (!many && $urandom_range(0, 1)) begin
      add_byte(rand_space());
      add_byte(CH_COLON);
      repeat ($urandom_range(0, 6)) add_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) begin
        add_byte(CH_CR);
        add_byte(CH_LF);
      end
    end else if ($urandom_range(0, 3) == 0) begin
      add_byte(rand_space());
    end
    flush_line();
  endtask

  // Sender stops until every queued byte is in and every result is out
  task automatic drain();
    while (line_bytes_q.size() > 0 || in_valid || pending_tokens_q.size() > 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Hand-built lines, both sides idling at random
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    add_text(":n!u");                     // line ends inside user field
    flush_line();
    add_text("-12 :");                    // negative code, empty trailing
    flush_line();
    add_text("a");                        // odd command bytes, CR LF cut
    add_byte(CH_MAX);
    add_byte(CH_NUL);
    add_text(" :");
    add_byte(CH_HI);
    add_byte(CH_SPACE);
    add_byte(CH_CR);
    add_byte(CH_LF);
    flush_line();
    add_text("99");                       // line ends inside command
    flush_line();
    add_text(":h");                       // line ends inside nick
    flush_line();
    add_text("x");
    add_byte(CH_TAB);
    add_text("y");
    add_byte(CH_VT);
    flush_line();
    drain();

    // Back to back, no idling on either side
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    while (n_pushed < 95)
      gen_line(1'b0);
    drain();

    // Random idling, starting with a saturating parameter run
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    gen_line(1'b1);
    while (n_pushed < 160)
      gen_line(1'b0);
    drain();

    // Long receiver hold while the sender keeps offering bytes
    tx_idle  = 1'b0;
    hold_req = ~hold_req;
    while (n_pushed < 215)
      gen_line(1'b0);
    drain();

    repeat (8) @(negedge clk);
    $display("Sent %0d bytes in %0d lines and checked %0d results,", n_pushed,
             n_lines, n_results);
    $display("across idle, back-to-back and long receiver hold phases.");
    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Timeout: %0d results still pending", pending_tokens_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
